@@ rtl/core/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash and round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic start;
  } rnd_ctl_t;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    round_k = k[i];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sha_round_unit.sv @@
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Shared round logic with rolling 16-word schedule; one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_round_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sha_pkg::rnd_ctl_t    ctl,
  input  wire logic [511:0]         block,
  input  wire logic [255:0]         chain_in,
  output logic                      done,
  output logic [255:0]              chain_out
);
  import sha_pkg::*;

  word_t w [16];
  word_t v [8];
  logic [5:0] rnd;
  logic       run;
  word_t wt, t1, t2, s0, s1, e, a;

  always_comb begin
    e  = v[4];
    a  = v[0];
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wt = w[0];
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + round_k(rnd) + wt;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      rnd  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
        rnd <= '0;
      end else if (run) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v[i] <= chain_in[255 - 32*i -: 32];
    end else if (run) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= s1 + w[9] + s0 + w[0];
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[255 - 32*i -: 32] = chain_in[255 - 32*i -: 32] + v[i];
  end
endmodule
`default_nettype wire

@@ rtl/core/sha256_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-stream SHA-256 with padding and four-part digest output.
// ----------------------------------------------------------------------------
// A byte request that fills a block runs the 64 rounds of the shared round
// unit plus start, load and fold before the next request is taken.
// An end mark runs one or two padding blocks and then offers four 64-bit
// digest parts; a new request is taken only after the last part has been
// accepted.
`default_nettype none
module sha256_stream_hasher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      digest_part,
  output logic             digest_last
);
  import sha_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HASH = 5'b00010,
    S_PAD  = 5'b00100,
    S_LEN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t       state;
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  logic [255:0] chain;
  logic         pend_end;
  logic         len_only;
  logic [1:0]   part;
  rnd_ctl_t     ctl;
  logic         done;
  logic [255:0] chain_new;
  logic         take;
  logic [511:0] pad_blk;

  assign take     = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign digest_part = chain[255 - 64*part -: 64];
  assign digest_last = (part == 2'd3);

  sha_round_unit u_round (
    .clk, .rst, .ctl, .block(blk), .chain_in(chain), .done, .chain_out(chain_new)
  );

  always_comb begin
    pad_blk = blk;
    for (int i = 0; i < 64; i++)
      if (i > int'(fill)) pad_blk[511 - 8*i -: 8] = 8'h00;
    pad_blk[511 - 8*fill -: 8] = 8'h80;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      bit_count <= '0;
      pend_end  <= 1'b0;
      len_only  <= 1'b0;
      part      <= '0;
      ctl.start <= 1'b0;
      for (int i = 0; i < 8; i++) chain[255 - 32*i -: 32] <= init_hash(3'(i));
    end else begin
      ctl.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            pend_end <= end_of_message;
            if (byte_valid) begin
              blk[511 - 8*fill -: 8] <= data_byte;
              bit_count <= bit_count + 64'd8;
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                ctl.start <= 1'b1;
                state <= S_HASH;
              end else if (end_of_message) begin
                state <= S_PAD;
              end
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          ctl.start <= 1'b1;
          if (len_only) begin
            blk <= {448'd0, bit_count};
            state <= S_LEN;
          end else if (fill > 6'd55) begin
            blk <= pad_blk;
            fill <= '0;
            len_only <= 1'b1;
            state <= S_HASH;
          end else begin
            blk <= {pad_blk[511:64], bit_count};
            state <= S_LEN;
          end
        end
        S_HASH: begin
          if (done) begin
            chain <= chain_new;
            if (pend_end) state <= S_PAD;
            else state <= S_IDLE;
          end
        end
        S_LEN: begin
          if (done) begin
            chain <= chain_new;
            part  <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            part <= part + 2'd1;
            if (part == 2'd3) begin
              state <= S_IDLE;
              fill <= '0;
              bit_count <= '0;
              pend_end <= 1'b0;
              len_only <= 1'b0;
              for (int i = 0; i < 8; i++) chain[255 - 32*i -: 32] <= init_hash(3'(i));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while output valid");
  a_last_part: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && digest_last) |=> in_ready) else $error("no return to idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(digest_part)) else $error("digest moved");
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte requests with end marks through the hasher, predicts each
// digest with a behavioral SHA-256 and checks the four parts in order under
// random sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } req_t;

  typedef struct packed {
    logic [63:0] part;
    logic        last;
  } digest_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] digest_part;
  logic        digest_last;
  logic        in_ready_seen;

  req_t    pending_reqs[$];
  digest_t expected_digests[$];

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] msg_bits;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  failed;
  bit  stim_done;
  int  quiet_cycles;

  sha256_stream_hasher_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_part    (digest_part),
    .digest_last    (digest_last)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      hash_state[i] += v[i];
  endtask

  task automatic restart_hash();
    hash_state = IV;
    block_fill = 0;
    msg_bits = '0;
  endtask

  task automatic hash_request(input req_t r);
    if (r.byte_valid) begin
      msg_block[block_fill] = r.data_byte;
      block_fill++;
      msg_bits += 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (r.end_of_message) begin
      msg_block[block_fill] = 8'h80;
      block_fill++;
      if (block_fill > 56) begin
        while (block_fill < 64) msg_block[block_fill++] = 8'h00;
        compress_block();
        block_fill = 0;
      end
      while (block_fill < 56) msg_block[block_fill++] = 8'h00;
      for (int i = 0; i < 8; i++)
        msg_block[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 4; i++)
        expected_digests.push_back('{{hash_state[2*i], hash_state[2*i+1]}, i == 3});
      restart_hash();
    end
  endtask

  task automatic add_req(input logic [7:0] b, input bit bv, input bit em);
    req_t r;
    r.data_byte = b;
    r.byte_valid = bv;
    r.end_of_message = em;
    pending_reqs.push_back(r);
  endtask

  task automatic add_message(input int len, input bit pattern);
    for (int i = 0; i < len; i++)
      add_req(pattern ? 8'(i) : 8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_digests.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // Driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        {data_byte, byte_valid, end_of_message} <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor, predictor and watchdog
  always @(posedge clk) begin
    in_ready_seen <= !rst && in_valid && in_ready;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (in_valid && in_ready)
        hash_request({data_byte, byte_valid, end_of_message});
      if (out_valid && out_ready) begin
        if (expected_digests.size() == 0) begin
          $error("unexpected digest part %h", digest_part);
          failed = 1'b1;
        end else begin
          digest_t e;
          e = expected_digests.pop_front();
          if (digest_part !== e.part) begin
            $error("digest_part expected %h actual %h", e.part, digest_part);
            failed = 1'b1;
          end
          if (digest_last !== e.last) begin
            $error("digest_last expected %b actual %b", e.last, digest_last);
            failed = 1'b1;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    byte_valid = 1'b0;
    end_of_message = 1'b0;
    out_ready = 1'b0;
    in_ready_seen = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    failed = 1'b0;
    stim_done = 1'b0;
    quiet_cycles = 0;
    restart_hash();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, byte with end mark, idle item, extremes,
    // padding needing a second block, exact block fill
    add_req(8'h00, 1'b0, 1'b1);
    add_req(8'hff, 1'b0, 1'b0);
    add_req(8'hff, 1'b1, 1'b1);
    add_req(8'h00, 1'b1, 1'b0);
    add_req(8'h5a, 1'b0, 1'b0);
    add_req(8'ha5, 1'b1, 1'b1);
    add_message(55, 1'b1); add_req(8'h00, 1'b0, 1'b1);
    add_message(56, 1'b1); add_req(8'h00, 1'b0, 1'b1);
    add_message(63, 1'b0); add_req(8'h80, 1'b1, 1'b1);
    add_message(64, 1'b0); add_req(8'h00, 1'b0, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 79 : 29) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 79 : 29) : 0;
      for (int m = 0; m < 4; m++) begin
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0)
            add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          add_req(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        if ($urandom_range(0, 1) == 1)
          add_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        else
          add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (failed || expected_digests.size() != 0)
      $display("FAILURE");
    else
      $display("SUCCESS");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/sha_pkg.sv
rtl/core/sha_round_unit.sv
rtl/core/sha256_stream_hasher_unit.sv
bench/testbench.sv
